// ----- rtl/core/acla_pkg.sv -----
// shared types, op codes and constants for the command line assembler
package acla_pkg;

    localparam int BUF_BYTES_DEF = 64;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [6:0] ERR_CHAR = 7'd32;

    localparam logic       KIND_CHAR = 1'b0;
    localparam logic       KIND_ERR  = 1'b1;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_NEWLINE = 2'd2;

    typedef struct packed {
        logic [1:0] code;
        logic [6:0] ch;
    } t_op;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

// ----- rtl/core/acla_front.sv -----
// input classifier: turns commands and raw bytes into line operations
module acla_front
    import acla_pkg::*;
(
    input  logic       i_valid,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    input  t_q_stat    i_q_stat,
    output logic       o_stall,
    output logic       o_push,
    output t_op        o_op
);

    logic keep;

    always_comb begin
        keep      = 1'b0;
        o_op.code = OP_CLEAR;
        o_op.ch   = i_rx_byte[6:0];
        if (i_command) begin
            keep      = 1'b1;
            o_op.code = OP_CLEAR;
        end else if (i_rx_byte == CH_LF) begin
            keep      = 1'b1;
            o_op.code = OP_NEWLINE;
        end else if (i_rx_byte >= PRINT_LO && i_rx_byte <= PRINT_HI) begin
            keep      = 1'b1;
            o_op.code = OP_APPEND;
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full && keep;

endmodule

// ----- rtl/core/acla_queue.sv -----
// short operation queue between classifier and line engine
module acla_queue
    import acla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    input  logic    i_pop,
    output t_op     o_op,
    output t_q_stat o_stat
);

    t_op             r_entry [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_stat.full      = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.not_empty = (r_cnt != '0);
    assign do_push          = i_push && !o_stat.full;
    assign do_pop           = i_pop && o_stat.not_empty;
    assign o_op             = r_entry[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_op;
        end
    end

endmodule

// ----- rtl/core/acla_back.sv -----
// line engine: line store, count, overflow flag and character drain
module acla_back
    import acla_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_result_kind,
    output logic [6:0] o_line_char,
    output logic       o_last
);

    localparam int CW = $clog2(BUF_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [6:0]    r_line_store [BUF_BYTES];
    logic [6:0]    r_rd_data;
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic          r_kind, n_kind;
    logic [6:0]    r_char, n_char;
    logic          r_last, n_last;
    logic          wr_en;
    logic          out_free;
    logic [CW:0]   count_inc;
    logic [CW:0]   idx_inc;

    assign out_free  = !r_out_valid || !i_stall;
    assign count_inc = (CW+1)'(r_count) + (CW+1)'(1);
    assign idx_inc   = (CW+1)'(r_idx) + (CW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.not_empty) begin
                    unique case (i_op.code)
                        OP_CLEAR: begin
                            o_pop   = 1'b1;
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        OP_APPEND: begin
                            o_pop = 1'b1;
                            if (!r_ovf) begin
                                if (count_inc >= (CW+1)'(BUF_BYTES)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    wr_en   = 1'b1;
                                    n_count = count_inc[CW-1:0];
                                end
                            end
                        end
                        OP_NEWLINE: begin
                            if (r_ovf) begin
                                if (out_free) begin
                                    o_pop       = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_kind      = KIND_ERR;
                                    n_char      = ERR_CHAR;
                                    n_last      = 1'b1;
                                    n_count     = '0;
                                    n_ovf       = 1'b0;
                                end
                            end else begin
                                o_pop = 1'b1;
                                if (r_count != '0) begin
                                    n_idx   = '0;
                                    n_state = ST_READ;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CHAR;
                    n_char      = r_rd_data;
                    n_last      = (idx_inc == (CW+1)'(r_count));
                    if (n_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = idx_inc[CW-1:0];
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_store[r_count] <= i_op.ch;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_line_store[r_idx];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_line_char   = r_char;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_count) < (CW+1)'(BUF_BYTES))
        else $error("line count beyond store capacity");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ERR) |-> (r_last && r_char == ERR_CHAR))
        else $error("error result without last marker");

    a_drain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (!r_ovf && r_count != '0 && !o_pop))
        else $error("drain with overflow, empty line or queue pop");

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_LOAD))
        else $error("store read not followed by load");

endmodule

// ----- rtl/core/ascii_command_line_assembler_core.sv -----
// top level of the ascii command line assembler
// timing: a byte is written into the queue at its transfer edge and sits at the head the next
// cycle when the queue was empty; an idle engine pops a newline at the head that cycle (on overflow
// only if the output is free); its error result is valid the next cycle
// throughput: one input transfer per cycle while the queue has room; the line engine takes one
// queued op per cycle while idle and drains characters via ST_READ, the store read, and ST_LOAD
// reset: synchronous, clears the queue, count, overflow flag and output valid; store is not cleared
module ascii_command_line_assembler_core
    import acla_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_result_kind,
    output logic [6:0] o_line_char,
    output logic       o_last
);

    t_q_stat q_stat;
    t_op     push_op;
    t_op     head_op;
    logic    push;
    logic    pop;

    acla_front u_front (
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_op      (push_op)
    );

    acla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (q_stat)
    );

    acla_back #(
        .BUF_BYTES (BUF_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (head_op),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_line_char   (o_line_char),
        .o_last        (o_last)
    );

endmodule
